// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/mtep_pkg.sv =====
package mtep_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] position;
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic [31:0] note_index;
    logic [31:0] partner_index;
    logic        partner_found;
    logic [25:0] tempo_bpm;
    logic [7:0]  sig_numerator;
    logic [30:0] sig_denominator;
  } out_t;

  localparam logic [2:0] KIND_ON    = 3'd0;
  localparam logic [2:0] KIND_OFF   = 3'd1;
  localparam logic [2:0] KIND_TEMPO = 3'd2;
  localparam logic [2:0] KIND_SIG   = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  localparam logic [2:0] OP_DELTA = 3'd0;
  localparam logic [2:0] OP_ON    = 3'd1;
  localparam logic [2:0] OP_OFF   = 3'd2;
  localparam logic [2:0] OP_TEMPO = 3'd3;
  localparam logic [2:0] OP_SIG   = 3'd4;
  localparam logic [2:0] OP_END   = 3'd5;

  // front-to-back command word
  typedef struct packed {
    logic [2:0]  op;
    logic        clr;
    logic [31:0] val;   // delta or microseconds per quarter
    logic [15:0] tpq;
    logic [7:0]  a;     // key or numerator
    logic [7:0]  b;     // velocity or denominator exponent
  } cmd_t;

  localparam int DIV_W  = 37;
  localparam int DVS_W  = 24;
  localparam logic [DIV_W-1:0] TEMPO_NUM = 37'd60000000;
  localparam logic [31:0] FIRST_POS = 32'd12;
  localparam logic [7:0] META_END   = 8'h2f;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_SIG   = 8'h58;

endpackage

// ===== src/midi_track_event_parser.sv =====
// channel | dir | payload                  | handshake
// in      | in  | in_word  (data_byte, restart) | in_valid / in_ready
// out     | out | out_word (event fields)   | out_valid / out_ready
//
// A byte is taken whenever the 4-word command queue has room.
// Delta and tempo commands run a 37-bit restoring divider (nonzero divisor only).
// A note-off scans the pending table one entry per cycle (up to PENDING_DEPTH).
// Reset (rst, synchronous) clears parser, queue and pending table at once.
// A stalled output holds the back end; the queue lets the front keep taking bytes.
module midi_track_event_parser #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mtep_pkg::in_t   in_word,
  output logic            out_valid,
  input  logic            out_ready,
  output mtep_pkg::out_t  out_word
);
  import mtep_pkg::*;

  logic q_full, q_push, q_pop, q_avail;
  cmd_t q_wdata, q_rdata;

  mtep_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_wdata)
  );

  mtep_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .avail(q_avail), .rdata(q_rdata)
  );

  mtep_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
    .clk(clk), .rst(rst), .avail(q_avail), .cmd(q_rdata), .pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );
endmodule

// ===== src/mtep_front.sv =====
module mtep_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mtep_pkg::in_t   in_word,
  input  logic            q_full,
  output logic            q_push,
  output mtep_pkg::cmd_t  q_cmd
);
  import mtep_pkg::*;

  localparam logic [3:0] PH_FILE_HDR  = 4'd0;
  localparam logic [3:0] PH_TRK_HDR   = 4'd1;
  localparam logic [3:0] PH_DELTA     = 4'd2;
  localparam logic [3:0] PH_STATUS    = 4'd3;
  localparam logic [3:0] PH_NOTE_KEY  = 4'd4;
  localparam logic [3:0] PH_NOTE_VEL  = 4'd5;
  localparam logic [3:0] PH_SKIP      = 4'd6;
  localparam logic [3:0] PH_META_TYPE = 4'd7;
  localparam logic [3:0] PH_META_LEN  = 4'd8;
  localparam logic [3:0] PH_META_DATA = 4'd9;

  logic [3:0]  phase, phase_next;
  logic [7:0]  bcnt, bcnt_next;
  logic [15:0] tpq, tpq_next;
  logic [31:0] dacc, dacc_next;
  logic [7:0]  status, status_next;
  logic [7:0]  key, key_next;
  logic [7:0]  mtype, mtype_next;
  logic [7:0]  mrem, mrem_next;
  logic [23:0] mval, mval_next;
  logic        clr_pend, clr_pend_next;
  logic        acc, emit;
  logic [7:0]  b;
  cmd_t        cmd;

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;
  assign b = in_word.data_byte;
  assign q_push = acc && emit;
  assign q_cmd = cmd;

  always_comb begin
    logic [3:0]  ph;
    logic [7:0]  bc;
    logic [15:0] tq;
    logic [31:0] da;
    logic [7:0]  mt;
    logic        fin;
    ph = phase; bc = bcnt; tq = tpq; da = dacc; mt = mtype;
    status_next = status; key_next = key; mrem_next = mrem; mval_next = mval;
    if (in_word.restart) begin
      ph = PH_FILE_HDR; bc = '0; tq = '0; da = '0; mt = '0;
      status_next = '0; key_next = '0; mrem_next = '0; mval_next = '0;
    end
    phase_next = ph; bcnt_next = bc; tpq_next = tq; dacc_next = da; mtype_next = mt;
    emit = 1'b0;
    fin = 1'b0;
    cmd = '0;
    cmd.clr = clr_pend | in_word.restart;
    cmd.tpq = tq;
    case (ph)
      PH_FILE_HDR: begin
        if (bc == 8'd12) tpq_next = {b, 8'h00};
        else if (bc == 8'd13) tpq_next = {tq[15:8], b};
        bcnt_next = bc + 8'd1;
        if (bc + 8'd1 >= 8'd14) begin
          phase_next = PH_TRK_HDR;
          bcnt_next = '0;
        end
      end
      PH_TRK_HDR: begin
        bcnt_next = bc + 8'd1;
        if (bc + 8'd1 >= 8'd8) begin
          phase_next = PH_DELTA;
          bcnt_next = '0;
          dacc_next = '0;
        end
      end
      PH_DELTA: begin
        dacc_next = {da[24:0], b[6:0]};
        if (!b[7]) begin
          emit = 1'b1;
          cmd.op = OP_DELTA;
          cmd.val = {da[24:0], b[6:0]};
          phase_next = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          status_next = b;
          if (b <= 8'haf) phase_next = PH_NOTE_KEY;
          else if (b <= 8'hbf) begin
            phase_next = PH_SKIP; bcnt_next = 8'd2;
          end else if (b <= 8'hdf) begin
            phase_next = PH_SKIP; bcnt_next = 8'd1;
          end else if (b == 8'hff) phase_next = PH_META_TYPE;
          else begin
            phase_next = PH_DELTA; dacc_next = '0;
          end
        end
      end
      PH_NOTE_KEY: begin
        key_next = b;
        phase_next = PH_NOTE_VEL;
      end
      PH_NOTE_VEL: begin
        phase_next = PH_DELTA;
        dacc_next = '0;
        emit = 1'b1;
        cmd.op = (status_next[7:4] == 4'h9) ? OP_ON : OP_OFF;
        cmd.a = key_next;
        cmd.b = b;
      end
      PH_SKIP: begin
        bcnt_next = (bc > 8'd0) ? bc - 8'd1 : bc;
        if (bcnt_next == 8'd0) begin
          phase_next = PH_DELTA; dacc_next = '0;
        end
      end
      PH_META_TYPE: begin
        mtype_next = b;
        phase_next = PH_META_LEN;
      end
      PH_META_LEN: begin
        mrem_next = b;
        mval_next = '0;
        bcnt_next = '0;
        if (b == 8'd0) fin = 1'b1;
        else phase_next = PH_META_DATA;
      end
      PH_META_DATA: begin
        case (bc)
          8'd0: mval_next[23:16] = mval_next[23:16] | b;
          8'd1: mval_next[15:8] = mval_next[15:8] | b;
          8'd2: mval_next[7:0] = mval_next[7:0] | b;
          default: ;
        endcase
        if (bc < 8'd255) bcnt_next = bc + 8'd1;
        if (mrem_next > 8'd0) mrem_next = mrem_next - 8'd1;
        if (mrem_next == 8'd0) fin = 1'b1;
      end
      default: begin
        phase_next = PH_FILE_HDR;
        bcnt_next = '0;
      end
    endcase
    if (fin) begin
      phase_next = PH_DELTA;
      dacc_next = '0;
      cmd.val = {8'h00, mval_next};
      cmd.a = mval_next[23:16];
      cmd.b = mval_next[15:8];
      if (mt == META_END) begin
        emit = 1'b1; cmd.op = OP_END;
        phase_next = PH_TRK_HDR; bcnt_next = '0;
      end else if (mt == META_TEMPO) begin
        emit = 1'b1; cmd.op = OP_TEMPO;
      end else if (mt == META_SIG) begin
        emit = 1'b1; cmd.op = OP_SIG;
      end
    end
    clr_pend_next = emit ? 1'b0 : cmd.clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FILE_HDR;
      bcnt <= '0; tpq <= '0; dacc <= '0; status <= '0; key <= '0;
      mtype <= '0; mrem <= '0; mval <= '0; clr_pend <= 1'b0;
    end else if (acc) begin
      phase <= phase_next; bcnt <= bcnt_next; tpq <= tpq_next; dacc <= dacc_next;
      status <= status_next; key <= key_next; mtype <= mtype_next;
      mrem <= mrem_next; mval <= mval_next; clr_pend <= clr_pend_next;
    end
  end
endmodule

// ===== src/mtep_queue.sv =====
module mtep_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mtep_pkg::cmd_t  wdata,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output mtep_pkg::cmd_t  rdata
);
  import mtep_pkg::*;

  cmd_t       slots [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign full = (cnt == 3'd4);
  assign avail = (cnt != 3'd0);
  assign rdata = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'b00, push} - {2'b00, pop};
    end
  end
endmodule

// ===== src/mtep_div.sv =====
module mtep_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mtep_pkg::DIV_W-1:0] dividend,
  input  logic [mtep_pkg::DVS_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [mtep_pkg::DIV_W-1:0] quotient
);
  import mtep_pkg::*;

  logic [DVS_W-1:0] rem, dvs;
  logic [DIV_W-1:0] quo;
  logic [5:0]       cnt;
  logic [DVS_W:0]   t;
  logic             ge;

  assign t = {rem, quo[DIV_W-1]};
  assign ge = (t >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cnt <= 6'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0; quo <= dividend; dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? DVS_W'(t - {1'b0, dvs}) : t[DVS_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end
endmodule

// ===== src/mtep_back.sv =====
module mtep_back #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  mtep_pkg::cmd_t  cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output mtep_pkg::out_t  out_word
);
  import mtep_pkg::*;

  localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_SRCH = 2'd2;

  logic [1:0]  st;
  logic        cleared, div_tempo;
  logic [31:0] pos, base, nc;
  logic [CW-1:0] pc, si;
  logic [7:0]  pn_note [PENDING_DEPTH];
  logic [31:0] pn_idx  [PENDING_DEPTH];
  logic [7:0]  skey;
  out_t        res;

  logic              div_start, div_busy, div_done;
  logic [DIV_W-1:0]  div_a, div_q;
  logic [DVS_W-1:0]  div_b;
  logic [IW-1:0]     sidx;
  logic [DIV_W-1:0]  d24;

  assign sidx = si[IW-1:0];
  assign d24 = {1'b0, cmd.val, 4'b0} + {2'b0, cmd.val, 3'b0};
  assign out_word = res;

  mtep_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  logic go;
  assign go = (st == B_IDLE) && avail && !out_valid && (cleared || !cmd.clr);
  assign pop = go;

  always_comb begin
    div_start = 1'b0;
    div_a = d24;
    div_b = {8'h00, cmd.tpq};
    if (go && cmd.op == OP_DELTA && cmd.tpq != 16'd0) div_start = 1'b1;
    if (go && cmd.op == OP_TEMPO && cmd.val[23:0] != 24'd0) begin
      div_start = 1'b1;
      div_a = TEMPO_NUM;
      div_b = cmd.val[23:0];
    end
  end

  always_ff @(posedge clk) begin
    out_t r;
    if (rst) begin
      st <= B_IDLE; cleared <= 1'b0; out_valid <= 1'b0;
      pos <= '0; nc <= '0; pc <= '0;
    end else begin
      r = res;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st)
        B_IDLE: begin
          if (avail && !out_valid && cmd.clr && !cleared) begin
            cleared <= 1'b1; pos <= '0; nc <= '0; pc <= '0;
          end else if (go) begin
            cleared <= 1'b0;
            r = '0;
            r.position = pos;
            case (cmd.op)
              OP_DELTA: begin
                base <= (nc == 32'd0) ? FIRST_POS : pos;
                if (cmd.tpq == 16'd0) begin
                  if (nc == 32'd0) pos <= FIRST_POS;
                end else begin
                  div_tempo <= 1'b0; st <= B_DIV;
                end
              end
              OP_ON: begin
                r.event_kind = KIND_ON;
                r.note = cmd.a; r.velocity = cmd.b; r.note_index = nc;
                nc <= nc + 32'd1;
                out_valid <= 1'b1;
                if (pc < DEPTH_C) begin
                  pn_note[pc[IW-1:0]] <= cmd.a;
                  pn_idx[pc[IW-1:0]] <= nc;
                  pc <= pc + CW'(1);
                end
              end
              OP_OFF: begin
                r.event_kind = KIND_OFF;
                r.note = cmd.a; r.velocity = cmd.b; r.note_index = nc;
                nc <= nc + 32'd1;
                skey <= cmd.a; si <= '0; st <= B_SRCH;
              end
              OP_TEMPO: begin
                r.event_kind = KIND_TEMPO;
                if (cmd.val[23:0] == 24'd0) out_valid <= 1'b1;
                else begin
                  div_tempo <= 1'b1; st <= B_DIV;
                end
              end
              OP_SIG: begin
                r.event_kind = KIND_SIG;
                r.sig_numerator = cmd.a;
                r.sig_denominator = (cmd.b >= 8'd30) ? 31'h4000_0000
                                    : (31'd1 << cmd.b[4:0]);
                out_valid <= 1'b1;
              end
              default: begin
                r.event_kind = KIND_END;
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        B_DIV: begin
          if (div_done) begin
            st <= B_IDLE;
            if (div_tempo) begin
              r.tempo_bpm = div_q[25:0];
              out_valid <= 1'b1;
            end else pos <= base + div_q[31:0];
          end
        end
        B_SRCH: begin
          if (si == pc) begin
            out_valid <= 1'b1; st <= B_IDLE;
          end else if (pn_note[sidx] == skey) begin
            r.partner_index = pn_idx[sidx];
            r.partner_found = 1'b1;
            out_valid <= 1'b1;
            pc <= pc - CW'(1);
            st <= B_IDLE;
            for (int j = 0; j < PENDING_DEPTH - 1; j++) begin
              if (CW'(j) >= si) begin
                pn_note[j] <= pn_note[j+1];
                pn_idx[j] <= pn_idx[j+1];
              end
            end
          end else si <= si + CW'(1);
        end
        default: st <= B_IDLE;
      endcase
      res <= r;
    end
  end
endmodule

// ===== src/mtep_checker.sv =====
`include "assert_macros.svh"
module mtep_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input mtep_pkg::out_t  out_word
);
  import mtep_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_word))
  `ASSERT_IMPL(a_kind_range, clk, rst, out_valid, out_word.event_kind <= KIND_END)
  `ASSERT_IMPL(a_sig_pow2, clk, rst, out_valid && out_word.event_kind == KIND_SIG, $onehot(out_word.sig_denominator))
  `ASSERT_IMPL(a_nomatch_zero, clk, rst, out_valid && !out_word.partner_found, out_word.partner_index == 32'd0)
endmodule

bind midi_track_event_parser mtep_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);
